@@ design/llqm_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the linked list queue manager.
// No dependencies; used by llqm_free_stack and linked_list_queue_manager.
package llqm_pkg;

	localparam int POOL_DEPTH = 64;
	localparam int IDX_W      = $clog2(POOL_DEPTH);
	localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
	localparam int VAL_W      = 32;

	// operation codes carried on s_tuser
	localparam logic [1:0] MODE_ENQ = 2'd0;
	localparam logic [1:0] MODE_DEQ = 2'd1;
	localparam logic [1:0] MODE_INS = 2'd2;

	// status codes carried on m_tuser
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_EMPTY   = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_BADMARK = 2'd3;

endpackage

@@ design/llqm_free_stack.sv @@
`timescale 1ns / 1ps
// Free node stack: synchronous memory with registered read.
// Entries never written read back as their own index. Depends on llqm_pkg.
module llqm_free_stack (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [llqm_pkg::IDX_W-1:0] rd_addr,
	output logic [llqm_pkg::IDX_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [llqm_pkg::IDX_W-1:0] wr_addr,
	input  logic [llqm_pkg::IDX_W-1:0] wr_data
);

	logic [llqm_pkg::IDX_W-1:0] mem [llqm_pkg::POOL_DEPTH];
	logic [llqm_pkg::POOL_DEPTH-1:0] written_q;
	logic [llqm_pkg::IDX_W-1:0] mem_rd_s1;
	logic [llqm_pkg::IDX_W-1:0] addr_s1;
	logic                       hit_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			addr_s1   <= '0;
			hit_s1    <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				addr_s1 <= rd_addr;
				hit_s1  <= written_q[rd_addr];
			end
		end
	end

	// untouched entries still hold their reset content: their own index
	assign rd_data = hit_s1 ? mem_rd_s1 : addr_s1;

endmodule

@@ design/linked_list_queue_manager.sv @@
`timescale 1ns / 1ps
// Linked list queue manager: a FIFO kept as a linked list in a pool of
// POOL_DEPTH nodes, with free nodes taken from a stack. Each input word is one
// operation selected by s_tuser (enqueue, dequeue, insert before a marker node)
// and yields exactly one result word with status, count and empty flag. One
// operation is in flight at a time: enqueue, dequeue, errors and no-ops make
// a read pass on the node, link and free stack memories, then a write pass;
// an insert into the middle of the list adds a second write pass, since the link
// memory has one write port and both the new node and the marker need a link
// written. Back pressure on the result side holds the operation until the output
// register frees up. No clearing pass is needed after reset. Depends on llqm_pkg
// and llqm_free_stack.
module linked_list_queue_manager (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value[31:0], marker[37:32], zero pad
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // result_value[31:0], node_index[37:32],
	                               // item_count[44:38], is_empty[45], zero pad
	output logic [1:0]  m_tuser    // status[1:0]
);

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_LINK} state_t;

	localparam int IW = llqm_pkg::IDX_W;
	localparam int CW = llqm_pkg::CNT_W;
	localparam int VW = llqm_pkg::VAL_W;

	state_t state_q;

	logic [1:0]    mode_q;
	logic [VW-1:0] value_q;
	logic [IW-1:0] marker_q;
	logic [IW-1:0] node_q;

	logic [IW-1:0] front_q;
	logic [IW-1:0] back_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] top_q;
	logic [llqm_pkg::POOL_DEPTH-1:0] live_q;

	logic          out_valid_q;
	logic [VW-1:0] out_value_q;
	logic [IW-1:0] out_idx_q;
	logic [1:0]    out_stat_q;
	logic [CW-1:0] out_count_q;

	logic [VW-1:0] val_mem [llqm_pkg::POOL_DEPTH];
	logic [IW-1:0] link_mem [llqm_pkg::POOL_DEPTH];
	logic [VW-1:0] val_rd_s1;
	logic [IW-1:0] link_rd_s1;

	logic          accept;
	logic          out_free;
	logic [IW-1:0] in_marker;
	logic [IW-1:0] link_raddr;
	logic [CW-1:0] top_dec;
	logic [IW-1:0] new_node;

	logic          marker_live;
	logic          bad_mark;
	logic          is_mid;

	logic          val_we;
	logic          link_we;
	logic [IW-1:0] link_waddr;
	logic [IW-1:0] link_wdata;
	logic          fs_we;
	logic          live_set;
	logic          live_clr;
	logic          to_link;
	logic          finish;
	logic [IW-1:0] front_d;
	logic [IW-1:0] back_d;
	logic [CW-1:0] count_d;
	logic [CW-1:0] top_d;
	logic [1:0]    stat_d;
	logic [VW-1:0] res_val_d;
	logic [IW-1:0] res_idx_d;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign in_marker = s_tdata[VW +: IW];
	assign link_raddr = (s_tuser == llqm_pkg::MODE_DEQ) ? front_q : in_marker;
	assign top_dec   = top_q - CW'(1);

	llqm_free_stack u_free_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (top_dec[IW-1:0]),
		.rd_data (new_node),
		.wr_en   (fs_we),
		.wr_addr (top_q[IW-1:0]),
		.wr_data (front_q)
	);

	// node value and toward-back link memories
	always_ff @(posedge clk) begin
		if (accept) begin
			val_rd_s1  <= val_mem[front_q];
			link_rd_s1 <= link_mem[link_raddr];
		end
		if (val_we) begin
			val_mem[new_node] <= value_q;
		end
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
	end

	assign marker_live = live_q[marker_q];
	assign bad_mark    = (count_q != '0) && !marker_live;
	assign is_mid      = (count_q != '0) && marker_live && (marker_q != back_q);

	always_comb begin
		val_we     = 1'b0;
		link_we    = 1'b0;
		link_waddr = back_q;
		link_wdata = new_node;
		fs_we      = 1'b0;
		live_set   = 1'b0;
		live_clr   = 1'b0;
		to_link    = 1'b0;
		finish     = 1'b0;
		front_d    = front_q;
		back_d     = back_q;
		count_d    = count_q;
		top_d      = top_q;
		stat_d     = llqm_pkg::STAT_OK;
		res_val_d  = '0;
		res_idx_d  = '0;
		if (state_q == ST_LINK) begin
			// second write pass of a middle insert: point the marker at the new node
			link_we    = out_free;
			link_waddr = marker_q;
			link_wdata = node_q;
			finish     = out_free;
			res_idx_d  = node_q;
		end else if (state_q == ST_EXEC && out_free) begin
			finish = 1'b1;
			case (mode_q)
				llqm_pkg::MODE_DEQ: begin
					if (count_q == '0) begin
						stat_d = llqm_pkg::STAT_EMPTY;
					end else begin
						res_val_d = val_rd_s1;
						fs_we     = 1'b1;
						live_clr  = 1'b1;
						top_d     = top_q + CW'(1);
						count_d   = count_q - CW'(1);
						if (count_q == CW'(1)) begin
							front_d = '0;
							back_d  = '0;
						end else begin
							front_d = link_rd_s1;
						end
					end
				end
				llqm_pkg::MODE_ENQ, llqm_pkg::MODE_INS: begin
					if (mode_q == llqm_pkg::MODE_INS && bad_mark) begin
						stat_d = llqm_pkg::STAT_BADMARK;
					end else if (top_q == '0) begin
						stat_d = llqm_pkg::STAT_FULL;
					end else begin
						val_we    = 1'b1;
						live_set  = 1'b1;
						top_d     = top_dec;
						count_d   = count_q + CW'(1);
						res_idx_d = new_node;
						if (mode_q == llqm_pkg::MODE_INS && is_mid) begin
							// new node takes over the marker's old back neighbor
							link_we    = 1'b1;
							link_waddr = new_node;
							link_wdata = link_rd_s1;
							to_link    = 1'b1;
							finish     = 1'b0;
						end else begin
							link_we = (count_q != '0);
							back_d  = new_node;
							if (count_q == '0) begin
								front_d = new_node;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= llqm_pkg::MODE_ENQ;
			value_q     <= '0;
			marker_q    <= '0;
			node_q      <= '0;
			front_q     <= '0;
			back_q      <= '0;
			count_q     <= '0;
			top_q       <= CW'(llqm_pkg::POOL_DEPTH);
			live_q      <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_idx_q   <= '0;
			out_stat_q  <= llqm_pkg::STAT_OK;
			out_count_q <= '0;
		end else begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
			top_q   <= top_d;
			if (live_set) begin
				live_q[new_node] <= 1'b1;
			end
			if (live_clr) begin
				live_q[front_q] <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
				out_value_q <= res_val_d;
				out_idx_q   <= res_idx_d;
				out_stat_q  <= stat_d;
				out_count_q <= count_d;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q   <= s_tuser;
						value_q  <= s_tdata[VW-1:0];
						marker_q <= in_marker;
						state_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (to_link) begin
						node_q  <= new_node;
						state_q <= ST_LINK;
					end else if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				ST_LINK: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tdata  = {2'b00, (out_count_q == '0), out_count_q, out_idx_q, out_value_q};

endmodule

@@ tb/sv/linked_list_queue_manager_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for linked_list_queue_manager: a directed opening, then
// random fill and drain phases with random gaps and stalls on both streams.
// Depends on llqm_pkg and the block itself; a scoreboard class tracks the list.
module linked_list_queue_manager_tb;

	localparam int POOL_DEPTH = llqm_pkg::POOL_DEPTH;
	localparam int IDX_W      = llqm_pkg::IDX_W;
	localparam int CNT_W      = llqm_pkg::CNT_W;
	localparam int VAL_W      = llqm_pkg::VAL_W;

	// mode 3 is an unused code that the block treats as a no-op
	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam int RANDOM_OPS = 2000;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] node;
		logic [1:0]       status;
		logic [CNT_W-1:0] count;
		logic             empty;
	} op_result_t;

	class list_tracker;
		logic [VAL_W-1:0] vals[POOL_DEPTH];
		logic [IDX_W-1:0] to_back[POOL_DEPTH];
		logic [IDX_W-1:0] to_front[POOL_DEPTH];
		bit               live[POOL_DEPTH];
		logic [IDX_W-1:0] free_stk[POOL_DEPTH];
		int               free_top;
		logic [IDX_W-1:0] front_idx;
		logic [IDX_W-1:0] back_idx;
		int               count;
		op_result_t       pending[$];
		int               mismatches;
		int               checked;

		function new();
			for (int i = 0; i < POOL_DEPTH; i++) begin
				live[i] = 0;
				free_stk[i] = IDX_W'(i);
			end
			free_top = POOL_DEPTH;
			front_idx = '0;
			back_idx = '0;
			count = 0;
			mismatches = 0;
			checked = 0;
		endfunction

		// pop a free node and link it in at the back
		function logic [1:0] append_node(logic [VAL_W-1:0] v, output logic [IDX_W-1:0] idx);
			logic [IDX_W-1:0] n;
			idx = '0;
			if (free_top == 0)
				return llqm_pkg::STAT_FULL;
			free_top--;
			n = free_stk[free_top];
			live[n] = 1;
			vals[n] = v;
			to_back[n] = n;
			if (count == 0) begin
				to_front[n] = n;
				front_idx = n;
			end else begin
				to_front[n] = back_idx;
				to_back[back_idx] = n;
			end
			back_idx = n;
			count++;
			idx = n;
			return llqm_pkg::STAT_OK;
		endfunction

		function void note_op(logic [1:0] mode, logic [VAL_W-1:0] v, logic [IDX_W-1:0] mk);
			op_result_t r;
			logic [IDX_W-1:0] n, f, p;
			r = '0;
			case (mode)
				llqm_pkg::MODE_ENQ: r.status = append_node(v, r.node);
				llqm_pkg::MODE_DEQ: begin
					if (count == 0) begin
						r.status = llqm_pkg::STAT_EMPTY;
					end else begin
						f = front_idx;
						r.value = vals[f];
						if (count == 1) begin
							front_idx = '0;
							back_idx = '0;
						end else begin
							front_idx = to_back[f];
							to_front[front_idx] = front_idx;
						end
						live[f] = 0;
						free_stk[free_top] = f;
						free_top++;
						count--;
					end
				end
				llqm_pkg::MODE_INS: begin
					if (count == 0 || (live[mk] && mk == back_idx)) begin
						r.status = append_node(v, r.node);
					end else if (!live[mk]) begin
						r.status = llqm_pkg::STAT_BADMARK;
					end else if (free_top == 0) begin
						r.status = llqm_pkg::STAT_FULL;
					end else begin
						// splice between the marker and its back-side neighbor
						free_top--;
						n = free_stk[free_top];
						live[n] = 1;
						p = to_back[mk];
						vals[n] = v;
						to_back[n] = p;
						to_front[n] = mk;
						to_front[p] = n;
						to_back[mk] = n;
						count++;
						r.node = n;
					end
				end
				default: ;
			endcase
			r.count = CNT_W'(count);
			r.empty = (count == 0);
			pending.push_back(r);
		endfunction

		// a live node, often the back one; anything when the list is empty
		function logic [IDX_W-1:0] pick_marker();
			logic [IDX_W-1:0] cand[$];
			if (count == 0)
				return IDX_W'($urandom_range(0, POOL_DEPTH - 1));
			if ($urandom_range(0, 3) == 0)
				return back_idx;
			for (int i = 0; i < POOL_DEPTH; i++)
				if (live[i])
					cand.push_back(IDX_W'(i));
			return cand[$urandom_range(0, cand.size() - 1)];
		endfunction

		task report(string field, longint got, longint want);
			$display("[%0t] word %0d: %s is %0h, expected %0h", $realtime, checked, field,
				got, want);
			mismatches++;
		endtask

		task check_result(logic [47:0] d, logic [1:0] st);
			op_result_t want;
			checked++;
			if (pending.size() == 0) begin
				report("unexpected word", d, 0);
				return;
			end
			want = pending.pop_front();
			if (d[31:0] !== want.value)
				report("result_value", d[31:0], want.value);
			if (d[37:32] !== want.node)
				report("node_index", d[37:32], want.node);
			if (st !== want.status)
				report("status", st, want.status);
			if (d[44:38] !== want.count)
				report("item_count", d[44:38], want.count);
			if (d[45] !== want.empty)
				report("is_empty", d[45], want.empty);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	bit          calm_send;
	bit          calm_recv;
	list_tracker book = new();

	linked_list_queue_manager DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	// called right after a rising edge; returns at the edge that took the word
	task send_op(logic [1:0] mode, logic [VAL_W-1:0] v, logic [IDX_W-1:0] mk);
		int gap;
		gap = calm_send ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, mk, v};
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		book.note_op(mode, v, mk);
	endtask

	// hold the input side until every outstanding result is back
	task wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (book.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin : result_sink
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = calm_recv ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			book.check_result(m_tdata, m_tuser);
		end
	end

	initial begin : stimulus
		int sent, phase_len, fill_pct, r;
		logic [1:0] mode;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = llqm_pkg::MODE_ENQ;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening: empty-list cases, value extremes, marker cases
		send_op(llqm_pkg::MODE_DEQ, 32'hFFFF_FFFF, 6'd63);
		send_op(MODE_NOP, 32'hFFFF_FFFF, 6'd63);
		send_op(llqm_pkg::MODE_INS, 32'h1234_5678, 6'd0);
		send_op(llqm_pkg::MODE_ENQ, 32'h0000_0000, 6'd0);
		send_op(llqm_pkg::MODE_ENQ, 32'hFFFF_FFFF, 6'd63);
		send_op(llqm_pkg::MODE_INS, 32'hDEAD_BEEF, 6'd0);
		send_op(llqm_pkg::MODE_INS, 32'hA5A5_A5A5, book.front_idx);
		send_op(llqm_pkg::MODE_INS, 32'h5A5A_5A5A, book.back_idx);
		send_op(llqm_pkg::MODE_INS, 32'h8000_0001, book.to_back[book.front_idx]);
		send_op(MODE_NOP, 32'h0F0F_0F0F, 6'd21);
		send_op(llqm_pkg::MODE_INS, 32'h7FFF_FFFE, 6'd42);
		repeat (7) send_op(llqm_pkg::MODE_DEQ, $urandom, IDX_W'($urandom_range(0, 63)));
		send_op(llqm_pkg::MODE_INS, 32'hCAFE_F00D, 6'd63);
		send_op(llqm_pkg::MODE_DEQ, 32'h0, 6'd0);
		wait_drained();

		// random phases that push the list toward full, toward empty or keep it level
		sent = 0;
		while (sent < RANDOM_OPS) begin
			phase_len = $urandom_range(20, 150);
			case ($urandom_range(0, 2))
				0: fill_pct = 85;
				1: fill_pct = 50;
				default: fill_pct = 15;
			endcase
			calm_send = ($urandom_range(0, 4) == 0);
			calm_recv = ($urandom_range(0, 4) == 0);
			repeat (phase_len) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					mode = MODE_NOP;
				else if (r < fill_pct)
					mode = $urandom_range(0, 1) ? llqm_pkg::MODE_INS : llqm_pkg::MODE_ENQ;
				else
					mode = llqm_pkg::MODE_DEQ;
				send_op(mode, $urandom,
					($urandom_range(0, 9) < 8) ? book.pick_marker()
						: IDX_W'($urandom_range(0, 63)));
				sent++;
			end
			if ($urandom_range(0, 3) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (book.mismatches == 0 && book.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
design/llqm_pkg.sv
design/llqm_free_stack.sv
design/linked_list_queue_manager.sv
tb/sv/linked_list_queue_manager_tb.sv
